// ----- rtl/delta_zigzag_varint_record_encoder_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the record encoder
// Concurrent checks on the rising clock with a synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef DELTA_ZIGZAG_VARINT_RECORD_ENCODER_MACROS_SVH
`define DELTA_ZIGZAG_VARINT_RECORD_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check prop at every edge outside reset.
`define DZV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dzv assertion failed");
// Check cons in the cycle after ante.
`define DZV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dzv assertion failed");
`else
`define DZV_ASSERT(lbl, clk, rst, prop)
`define DZV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/dzv_pkg.sv -----
// ---------------------------------------------------------------------------
// dzv_pkg
// Shared constants, result codes and helpers of the record encoder.
// ---------------------------------------------------------------------------
package dzv_pkg;

   localparam int FIELDS         = 3;
   localparam int PAYLOAD_BUDGET = 4080;

   localparam int WORD_W    = 64;
   localparam int FIELD_NUM = 3;
   localparam int FLD_W     = $clog2(FIELD_NUM);
   localparam int MAX_LEN   = 10 * FIELDS;
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int CNT_W     = $clog2(PAYLOAD_BUDGET + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int OUT_CNT_W = 12;

   typedef logic [1:0]        status_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam status_type ST_BYTE    = 2'd0;
   localparam status_type ST_REJECT  = 2'd1;
   localparam status_type ST_NEWPAGE = 2'd2;

   // Low bits of a count as carried on the result channel.
   function automatic logic [OUT_CNT_W-1:0] out_count(input logic [CNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return wide[OUT_CNT_W-1:0];
   endfunction

endpackage

// ----- rtl/dzv_delta_unit.sv -----
// ---------------------------------------------------------------------------
// dzv_delta_unit
// Shared field coder: wrapping difference and zigzag map, or raw value.
// ---------------------------------------------------------------------------
module dzv_delta_unit (
   input  dzv_pkg::word_type cur,
   input  dzv_pkg::word_type prev,
   input  logic              use_delta,
   output dzv_pkg::word_type value
);

   dzv_pkg::word_type diff;

   assign diff  = cur - prev;
   // zigzag: shift left one, flip every bit when negative
   assign value = use_delta ? ({diff[dzv_pkg::WORD_W-2:0], 1'b0} ^ {dzv_pkg::WORD_W{diff[dzv_pkg::WORD_W-1]}})
                            : cur;

endmodule

// ----- rtl/delta_zigzag_varint_record_encoder.sv -----
// ---------------------------------------------------------------------------
// delta_zigzag_varint_record_encoder
// Record encoder: per-field delta, zigzag map and LEB128 varint bytes.
// ---------------------------------------------------------------------------
// Takes one item at a time. A new-page item yields a single acknowledge
// result. An append item is worked by one shared delta/zigzag unit and a
// 64-bit work register shifted right by seven bits: after the accept a
// sizing pass loads each field and counts its encoded bytes, a check state
// tests the page budget, then an emit pass loads each field and sends its
// bytes, waiting while the result side stalls. A rejected record gives one
// result with status 1 and changes nothing. Results leave through a single
// output register; an item is taken only while the sequencer is idle and
// that register is empty or being read in the same cycle.
// There is no clearing pass after reset; previous field values are only
// read once a record has been accepted on the page.
// ---------------------------------------------------------------------------
`include "delta_zigzag_varint_record_encoder_macros.svh"

module delta_zigzag_varint_record_encoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_kind,
   input  logic [63:0]                    req_field_a,
   input  logic [63:0]                    req_field_b,
   input  logic [63:0]                    req_field_c,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_last,
   output logic [11:0]                    rsp_records_on_page,
   output logic [11:0]                    rsp_payload_used
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;  // wait for an item
   localparam logic [2:0] S_LOAD  = 3'd1;  // size pass: code one field
   localparam logic [2:0] S_COUNT = 3'd2;  // size pass: count its bytes
   localparam logic [2:0] S_CHECK = 3'd3;  // budget test and commit
   localparam logic [2:0] S_ELOAD = 3'd4;  // emit pass: code one field
   localparam logic [2:0] S_EMIT  = 3'd5;  // emit pass: one byte a cycle unless stalled

   localparam logic [dzv_pkg::FLD_W-1:0] LAST_FLD = dzv_pkg::FLD_W'(dzv_pkg::FIELDS - 1);
   localparam logic [dzv_pkg::SUM_W-1:0] BUDGET   = dzv_pkg::SUM_W'(dzv_pkg::PAYLOAD_BUDGET);

   logic [2:0]                      state_ff, state_in;
   dzv_pkg::word_type               rec_ff  [dzv_pkg::FIELD_NUM];
   dzv_pkg::word_type               rec_in  [dzv_pkg::FIELD_NUM];
   dzv_pkg::word_type               prev_ff [dzv_pkg::FIELD_NUM];
   dzv_pkg::word_type               prev_in [dzv_pkg::FIELD_NUM];
   logic                            have_prev_ff, have_prev_in;
   logic [dzv_pkg::CNT_W-1:0]       pay_ff, pay_in;
   logic [dzv_pkg::CNT_W-1:0]       nrec_ff, nrec_in;
   logic [dzv_pkg::FLD_W-1:0]       fld_ff, fld_in;
   logic [dzv_pkg::LEN_W-1:0]       len_ff, len_in;
   dzv_pkg::word_type               work_ff, work_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      byte_ff, byte_in;
   dzv_pkg::status_type             status_ff, status_in;
   logic                            last_ff, last_in;
   logic [11:0]                     orec_ff, orec_in;
   logic [11:0]                     opay_ff, opay_in;

   dzv_pkg::word_type               unit_value;
   logic                            out_free;
   logic                            more;
   logic [dzv_pkg::SUM_W-1:0]       sum;

   dzv_delta_unit u_delta (
      .cur       (rec_ff[fld_ff]),
      .prev      (prev_ff[fld_ff]),
      .use_delta (have_prev_ff),
      .value     (unit_value)
   );

   // output register can take a new result this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign more      = |work_ff[dzv_pkg::WORD_W-1:7];
   assign sum       = dzv_pkg::SUM_W'(pay_ff) + dzv_pkg::SUM_W'(len_ff);
   assign req_stall = !((state_ff == S_IDLE) && out_free);

   always_comb begin
      state_in     = state_ff;
      rec_in       = rec_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      pay_in       = pay_ff;
      nrec_in      = nrec_ff;
      fld_in       = fld_ff;
      len_in       = len_ff;
      work_in      = work_ff;
      // drop the held result once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      byte_in      = byte_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      orec_in      = orec_ff;
      opay_in      = opay_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && out_free) begin
               if (req_kind) begin
                  // empty the page and acknowledge at once
                  have_prev_in = 1'b0;
                  pay_in       = '0;
                  nrec_in      = '0;
                  rsp_valid_in = 1'b1;
                  byte_in      = 8'd0;
                  status_in    = dzv_pkg::ST_NEWPAGE;
                  last_in      = 1'b1;
                  orec_in      = 12'd0;
                  opay_in      = 12'd0;
               end else begin
                  rec_in[0] = req_field_a;
                  rec_in[1] = req_field_b;
                  rec_in[2] = req_field_c;
                  fld_in    = '0;
                  len_in    = '0;
                  state_in  = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            work_in  = unit_value;
            state_in = S_COUNT;
         end
         S_COUNT: begin
            len_in = len_ff + 1'b1;
            if (!more) begin
               if (fld_ff == LAST_FLD) begin
                  state_in = S_CHECK;
               end else begin
                  fld_in   = fld_ff + 1'b1;
                  state_in = S_LOAD;
               end
            end else begin
               work_in = work_ff >> 7;
            end
         end
         S_CHECK: begin
            if (sum > BUDGET) begin
               // reject: one result, state untouched
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  byte_in      = 8'd0;
                  status_in    = dzv_pkg::ST_REJECT;
                  last_in      = 1'b1;
                  orec_in      = dzv_pkg::out_count(nrec_ff);
                  opay_in      = dzv_pkg::out_count(pay_ff);
                  state_in     = S_IDLE;
               end
            end else begin
               // commit counts now; previous record advances after last byte
               pay_in   = sum[dzv_pkg::CNT_W-1:0];
               nrec_in  = nrec_ff + 1'b1;
               fld_in   = '0;
               state_in = S_ELOAD;
            end
         end
         S_ELOAD: begin
            work_in  = unit_value;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               byte_in      = {more, work_ff[6:0]};
               status_in    = dzv_pkg::ST_BYTE;
               last_in      = !more && (fld_ff == LAST_FLD);
               orec_in      = dzv_pkg::out_count(nrec_ff);
               opay_in      = dzv_pkg::out_count(pay_ff);
               if (more) begin
                  work_in = work_ff >> 7;
               end else if (fld_ff == LAST_FLD) begin
                  prev_in      = rec_ff;
                  have_prev_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  fld_in   = fld_ff + 1'b1;
                  state_in = S_ELOAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_prev_ff <= 1'b0;
         pay_ff       <= '0;
         nrec_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         pay_ff       <= pay_in;
         nrec_ff      <= nrec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rec_ff    <= rec_in;
      prev_ff   <= prev_in;
      fld_ff    <= fld_in;
      len_ff    <= len_in;
      work_ff   <= work_in;
      byte_ff   <= byte_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      orec_ff   <= orec_in;
      opay_ff   <= opay_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_status          = status_ff;
   assign rsp_last            = last_ff;
   assign rsp_records_on_page = orec_ff;
   assign rsp_payload_used    = opay_ff;

   `DZV_ASSERT(a_busy_stalls, clock, reset, (state_ff != S_IDLE) |-> req_stall)
   `DZV_ASSERT(a_len_bound, clock, reset,
      (state_ff == S_CHECK) |-> (len_ff <= dzv_pkg::LEN_W'(dzv_pkg::MAX_LEN)))
   `DZV_ASSERT(a_pay_bound, clock, reset,
      dzv_pkg::SUM_W'(pay_ff) <= BUDGET)
   `DZV_ASSERT(a_ctrl_is_last, clock, reset,
      (rsp_valid_ff && (status_ff != dzv_pkg::ST_BYTE)) |-> last_ff)
   `DZV_ASSERT_NEXT(a_commit_on_last, clock, reset,
      (state_ff == S_EMIT) && out_free && !more && (fld_ff == LAST_FLD),
      have_prev_ff && (state_ff == S_IDLE))

endmodule

// ----- dv/delta_zigzag_varint_record_encoder_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Record encoder checker
// Watches both channels of the record encoder and predicts every result of
// each accepted item. Compares each accepted result field by field with the
// oldest prediction and hands failure and coverage counts to the top.
// ---------------------------------------------------------------------------
module delta_zigzag_varint_record_encoder_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_kind,
   input  logic [63:0]          req_field_a,
   input  logic [63:0]          req_field_b,
   input  logic [63:0]          req_field_c,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [7:0]           rsp_out_byte,
   input  logic [1:0]           rsp_status,
   input  logic                 rsp_last,
   input  logic [11:0]          rsp_records_on_page,
   input  logic [11:0]          rsp_payload_used,
   output int                   fail_count,
   output int                   outstanding,
   output int                   records_seen,
   output int                   bytes_seen,
   output int                   rejects_seen,
   output int                   pages_seen
);

   typedef struct packed {
      logic [7:0]                    out_byte;
      dzv_pkg::status_type           status;
      logic                          last;
      logic [dzv_pkg::OUT_CNT_W-1:0] records_on_page;
      logic [dzv_pkg::OUT_CNT_W-1:0] payload_used;
   } enc_result_type;

   enc_result_type    encoded_q[$];
   dzv_pkg::word_type prev_rec [dzv_pkg::FIELD_NUM];
   logic              have_prev;
   int unsigned       page_fill;
   int unsigned       page_records;
   int                n_fail    = 0;
   int                n_records = 0;
   int                n_bytes   = 0;
   int                n_rejects = 0;
   int                n_pages   = 0;

   function automatic dzv_pkg::word_type zigzag(input dzv_pkg::word_type d);
      return (d << 1) ^ {dzv_pkg::WORD_W{d[dzv_pkg::WORD_W-1]}};
   endfunction

   function automatic enc_result_type make_result(input logic [7:0] b,
                                                  input dzv_pkg::status_type st,
                                                  input logic is_last);
      enc_result_type r;
      r.out_byte        = b;
      r.status          = st;
      r.last            = is_last;
      r.records_on_page = page_records[dzv_pkg::OUT_CNT_W-1:0];
      r.payload_used    = page_fill[dzv_pkg::OUT_CNT_W-1:0];
      return r;
   endfunction

   // Predict all results of one accepted item and update the page state.
   task automatic encode_item(input logic kind, input dzv_pkg::word_type a,
                              input dzv_pkg::word_type b, input dzv_pkg::word_type c);
      dzv_pkg::word_type rec [dzv_pkg::FIELD_NUM];
      logic [7:0]        enc [dzv_pkg::MAX_LEN];
      dzv_pkg::word_type v;
      int unsigned       len;
      int unsigned       n;
      int                j;
      rec[0] = a;
      rec[1] = b;
      rec[2] = c;
      if (kind) begin
         have_prev    = 1'b0;
         page_fill    = 0;
         page_records = 0;
         encoded_q.push_back(make_result(8'd0, dzv_pkg::ST_NEWPAGE, 1'b1));
         n_pages++;
         return;
      end
      len = 0;
      for (j = 0; j < dzv_pkg::FIELDS; j++) begin
         v = have_prev ? zigzag(rec[j] - prev_rec[j]) : rec[j];
         n = 0;
         do begin
            enc[len] = {(v >> 7) != 0, v[6:0]};
            v = v >> 7;
            len++;
            n++;
         end while (v != 0 && n < 10);
      end
      if (page_fill + len > dzv_pkg::PAYLOAD_BUDGET) begin
         encoded_q.push_back(make_result(8'd0, dzv_pkg::ST_REJECT, 1'b1));
         n_rejects++;
         return;
      end
      for (j = 0; j < dzv_pkg::FIELDS; j++)
         prev_rec[j] = rec[j];
      have_prev = 1'b1;
      page_fill += len;
      page_records++;
      n_records++;
      n_bytes += len;
      for (j = 0; j < len; j++)
         encoded_q.push_back(make_result(enc[j], dzv_pkg::ST_BYTE, j == len - 1));
   endtask

   task automatic compare_field(input string name, input logic [11:0] want,
                                input logic [11:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         n_fail++;
      end
   endtask

   task automatic check_result();
      enc_result_type want;
      if (encoded_q.size() == 0) begin
         $error("result with nothing pending: out_byte %0h status %0d last %0b",
                rsp_out_byte, rsp_status, rsp_last);
         n_fail++;
         return;
      end
      want = encoded_q.pop_front();
      compare_field("out_byte", 12'(want.out_byte), 12'(rsp_out_byte));
      compare_field("status", 12'(want.status), 12'(rsp_status));
      compare_field("last", 12'(want.last), 12'(rsp_last));
      compare_field("records_on_page", want.records_on_page, rsp_records_on_page);
      compare_field("payload_used", want.payload_used, rsp_payload_used);
   endtask

   // Results of an item only appear after the edge that takes it, so check
   // before predicting.
   always @(posedge clock) begin
      if (reset) begin
         encoded_q.delete();
         have_prev    = 1'b0;
         page_fill    = 0;
         page_records = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            encode_item(req_kind, req_field_a, req_field_b, req_field_c);
      end
      fail_count   <= n_fail;
      outstanding  <= encoded_q.size();
      records_seen <= n_records;
      bytes_seen   <= n_bytes;
      rejects_seen <= n_rejects;
      pages_seen   <= n_pages;
   end

endmodule

// ----- dv/delta_zigzag_varint_record_encoder_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Record encoder testbench
// Drives directed and random records and new-page items into the encoder
// under four idling mixes and one long receiver hold-off, while the checker
// predicts and compares every encoded byte, reject and page acknowledge.
// ---------------------------------------------------------------------------
module delta_zigzag_varint_record_encoder_tb;

   localparam logic KIND_RECORD     = 1'b0;
   localparam logic KIND_PAGE       = 1'b1;
   localparam int   HOLD_CYCLES     = 400;
   localparam int   WATCHDOG_LIMIT  = 4000;
   localparam int   DRAIN_CYCLES    = 100;
   localparam int   ITEMS_PER_PHASE = 104;
   localparam int   REJECTS_PER_PAGE = 5;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [63:0] req_field_a;
   logic [63:0] req_field_b;
   logic [63:0] req_field_c;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   logic [11:0] rsp_records_on_page;
   logic [11:0] rsp_payload_used;

   int fail_count;
   int outstanding;
   int records_seen;
   int bytes_seen;
   int rejects_seen;
   int pages_seen;

   // Stimulus knobs; the stall mix and hold request are read by the
   // receiver process, so they change only by nonblocking assignment.
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                hold_seq      = 0;
   int                hold_seen     = 0;
   int                hold_cnt;
   int                reject_mark   = 0;
   dzv_pkg::word_type last_sent [dzv_pkg::FIELD_NUM];

   delta_zigzag_varint_record_encoder dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_field_a         (req_field_a),
      .req_field_b         (req_field_b),
      .req_field_c         (req_field_c),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_status          (rsp_status),
      .rsp_last            (rsp_last),
      .rsp_records_on_page (rsp_records_on_page),
      .rsp_payload_used    (rsp_payload_used)
   );

   delta_zigzag_varint_record_encoder_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_field_a         (req_field_a),
      .req_field_b         (req_field_b),
      .req_field_c         (req_field_c),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_status          (rsp_status),
      .rsp_last            (rsp_last),
      .rsp_records_on_page (rsp_records_on_page),
      .rsp_payload_used    (rsp_payload_used),
      .fail_count          (fail_count),
      .outstanding         (outstanding),
      .records_seen        (records_seen),
      .bytes_seen          (bytes_seen),
      .rejects_seen        (rejects_seen),
      .pages_seen          (pages_seen)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Offer one item. Idle first according to the sender mix (with an
   // occasional long gap), then hold valid and payload until taken. Valid
   // is assigned once per edge, so back-to-back items never glitch it.
   task automatic send_item(input logic kind, input dzv_pkg::word_type a,
                            input dzv_pkg::word_type b, input dzv_pkg::word_type c);
      int unsigned gap;
      gap = 0;
      if (send_idle_pct > 0 && $urandom_range(9) == 0)
         gap = $urandom_range(1, 80);
      while (gap > 0 || $urandom_range(99) < send_idle_pct) begin
         req_valid   <= 1'b0;
         req_kind    <= $urandom_range(1);
         req_field_a <= {$urandom, $urandom};
         req_field_b <= {$urandom, $urandom};
         req_field_c <= {$urandom, $urandom};
         if (gap > 0)
            gap--;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_field_a <= a;
      req_field_b <= b;
      req_field_c <= c;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_record(input dzv_pkg::word_type a, input dzv_pkg::word_type b,
                              input dzv_pkg::word_type c);
      send_item(KIND_RECORD, a, b, c);
      last_sent[0] = a;
      last_sent[1] = b;
      last_sent[2] = c;
   endtask

   task automatic send_page();
      send_item(KIND_PAGE, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
   endtask

   // Pick one field value relative to the last one sent. Nearly half the picks
   // move by about half the number range, which costs ten bytes per field and
   // fills the page fast enough to reach the budget several times.
   function automatic dzv_pkg::word_type next_field(input dzv_pkg::word_type prev);
      dzv_pkg::word_type w;
      int unsigned       sel;
      int unsigned       nbits;
      int                step;
      sel = $urandom_range(99);
      w   = {$urandom, $urandom};
      if (sel < 45) begin
         step = $urandom_range(0, 6) - 3;
         w    = prev + 64'h8000_0000_0000_0000 + dzv_pkg::word_type'(longint'(step));
      end else if (sel < 60) begin
         // keep the full random value
      end else if (sel < 75) begin
         step = $urandom_range(0, 16383) - 8192;
         w    = prev + dzv_pkg::word_type'(longint'(step));
      end else if (sel < 85) begin
         nbits = $urandom_range(0, 64);
         w     = (nbits == 0) ? '0 : w >> (64 - nbits);
      end else if (sel < 95) begin
         w = prev;
      end else begin
         case ($urandom_range(3))
            0:       w = 64'h0000_0000_0000_0000;
            1:       w = 64'hFFFF_FFFF_FFFF_FFFF;
            2:       w = 64'h8000_0000_0000_0000;
            default: w = 64'h7FFF_FFFF_FFFF_FFFF;
         endcase
      end
      return w;
   endfunction

   // Start a fresh page now and then, and always once the current page has
   // turned away a few records at its budget.
   task automatic send_random_item();
      dzv_pkg::word_type f [dzv_pkg::FIELD_NUM];
      int                j;
      if ($urandom_range(199) == 0 || rejects_seen - reject_mark >= REJECTS_PER_PAGE) begin
         reject_mark = rejects_seen;
         send_page();
      end else begin
         for (j = 0; j < dzv_pkg::FIELD_NUM; j++)
            f[j] = next_field(last_sent[j]);
         send_record(f[0], f[1], f[2]);
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input logic with_hold);
      int k;
      send_idle_pct = send_pct;
      rsp_stall_pct <= recv_pct;
      if (with_hold)
         hold_seq <= hold_seq + 1;
      for (k = 0; k < ITEMS_PER_PHASE; k++)
         send_random_item();
   endtask

   // Receiver: stall per the current mix; on a hold request keep stall high
   // for a long counted stretch so the encoder backs up into its input.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_kind    <= KIND_RECORD;
      req_field_a <= '0;
      req_field_b <= '0;
      req_field_c <= '0;
      last_sent[0] = '0;
      last_sent[1] = '0;
      last_sent[2] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: first record after reset goes raw, then deltas of zero,
      // plus and minus one, the 7-bit boundaries and the half-range extremes.
      send_record(64'd0, 64'd0, 64'd0);
      send_record(64'd1, 64'd127, 64'd128);
      send_record(64'd0, 64'd191, 64'd64);
      send_page();
      // Raw record on a fresh page: ten, one and two bytes.
      send_record(64'hFFFF_FFFF_FFFF_FFFF, 64'd127, 64'd128);
      send_record(64'hFFFF_FFFF_FFFF_FFFF, 64'd127, 64'd128);
      send_record(64'd0, 64'd0, 64'd0);
      send_record(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
      send_record(64'd63, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0040);
      send_record(64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      // Back-to-back page starts, then a raw record again.
      send_page();
      send_page();
      send_record(64'h0123_4567_89AB_CDEF, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
      send_record(64'h0123_4567_89AB_CDEE, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      send_record(64'h0123_4567_89AB_CDEE, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      send_record({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      send_record(64'd0, 64'd0, 64'd0);
      send_page();
      send_record(64'd0, 64'd0, 64'd0);
      send_record(64'd0, 64'd0, 64'd0);

      // Random phases; the first one carries the long receiver hold-off.
      run_phase(0, 0, 1'b1);
      run_phase(72, 0, 1'b0);
      run_phase(0, 72, 1'b0);
      run_phase(36, 36, 1'b0);

      // Drain: wait for every predicted result, then watch a while longer
      // for anything extra.
      req_valid <= 1'b0;
      rsp_stall_pct <= 0;
      @(posedge clock);
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Encoded %0d records into %0d bytes, %0d records turned away at the budget,",
               records_seen, bytes_seen, rejects_seen);
      $display("%0d page starts, over four idling mixes and a %0d-cycle receiver hold-off.",
               pages_seen, HOLD_CYCLES);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
